[rtl/lpg_pkg.sv]
// Shared types, widths and register codes for the lattice position generator.
// Used by every module under rtl/; depends on nothing else.
package lpg_pkg;

  localparam int MAX_PARTICLES = 65536;
  localparam int EXCESS_CUTOFF = 3;

  localparam int COUNT_W    = 17;              // particle_count register
  localparam int IDX_W      = 16;              // particle_index
  localparam int AXIS_W     = 21;              // one axis component
  localparam int AXIS_REG_W = 3 * AXIS_W;      // packed x,y,z
  localparam int POS_W      = 24;              // output coordinate
  localparam int NUM_W      = IDX_W + 1;       // 2*layer+1
  localparam int CUBE_W     = COUNT_W + 1;     // cube root search

  // Shared divider: quotient always fits the axis magnitude width
  localparam int QUOT_W = AXIS_W;
  localparam int DIVR_W = COUNT_W + 1;         // 2*grid size
  localparam int DIVD_W = QUOT_W + DIVR_W;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  localparam logic [1:0] REG_COUNT  = 2'd0;
  localparam logic [1:0] REG_FIRST  = 2'd1;
  localparam logic [1:0] REG_SECOND = 2'd2;
  localparam logic [1:0] REG_THIRD  = 2'd3;

  localparam logic [COUNT_W-1:0] MAX_N = COUNT_W'(MAX_PARTICLES);

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic [DIVR_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [COUNT_W-1:0] gx;
    logic [COUNT_W-1:0] gy;
    logic [COUNT_W-1:0] gz;
    logic [COUNT_W-1:0] plane;
  } grid_t;

  // Pick component k (0 x, 1 y, 2 z) of a packed axis register
  function automatic logic signed [AXIS_W-1:0] axis_comp(
    input logic [AXIS_REG_W-1:0] vec,
    input logic [1:0]            k
  );
    logic signed [AXIS_W-1:0] v;
    case (k)
      2'd0:    v = vec[AXIS_W-1:0];
      2'd1:    v = vec[2*AXIS_W-1:AXIS_W];
      2'd2:    v = vec[3*AXIS_W-1:2*AXIS_W];
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[rtl/lpg_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on lpg_pkg (request/response structs and widths).
module lpg_div import lpg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic              running;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [DIVR_W-1:0] r;
  logic [QUOT_W-1:0] q;
  logic [DIVR_W-1:0] divisor;
  logic [DIVR_W:0]   rr;
  logic [DIVR_W:0]   diff;

  // Trial subtract of the shifted partial remainder
  assign rr   = {r, q[QUOT_W-1]};
  assign diff = rr - {1'b0, divisor};

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !running) begin
        running <= 1'b1;
        cnt     <= CNT_W'(QUOT_W);
      end else if (running) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: load the operands, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start && !running) begin
      r       <= req.dividend[DIVD_W-1:QUOT_W];
      q       <= req.dividend[QUOT_W-1:0];
      divisor <= req.divisor;
    end else if (running) begin
      if (!diff[DIVR_W]) begin
        r <= diff[DIVR_W-1:0];
        q <= {q[QUOT_W-2:0], 1'b1};
      end else begin
        r <= rr[DIVR_W-1:0];
        q <= {q[QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = q;
  assign rsp.rem  = r;

endmodule

[rtl/lpg_grid.sv]
// Grid size sequencer: cube root search, then trial-division factoring
// dealt round-robin to y, z, x. Depends on lpg_pkg and the shared divider.
module lpg_grid import lpg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               kick,
  input  logic [COUNT_W-1:0] n,
  output div_req_t           div_req,
  input  div_rsp_t           div_rsp,
  output grid_t              grid,
  output logic               busy
);

  localparam logic [2:0] G_IDLE  = 3'd0;
  localparam logic [2:0] G_CUBE  = 3'd1;
  localparam logic [2:0] G_TEST  = 3'd2;
  localparam logic [2:0] G_WAIT  = 3'd3;
  localparam logic [2:0] G_CHECK = 3'd4;
  localparam logic [2:0] G_PLANE = 3'd5;

  logic [2:0]         state;
  logic [COUNT_W-1:0] n_r;
  logic [COUNT_W-1:0] rest;
  logic [COUNT_W-1:0] d;
  logic [DIVR_W-1:0]  dsq;
  logic [1:0]         slot;
  logic [COUNT_W-1:0] g [3];
  logic [COUNT_W-1:0] c;
  logic [CUBE_W-1:0]  cube;
  logic [CUBE_W-1:0]  sq;
  logic [COUNT_W-1:0] plane;

  logic [CUBE_W-1:0]    c_ext;
  logic [CUBE_W-1:0]    cube_add;
  logic [CUBE_W-1:0]    sq_add;
  logic                 d_past_root;
  logic [COUNT_W-1:0]   d_try;
  logic [COUNT_W-1:0]   g_slot;
  logic [2*COUNT_W-1:0] g_mul;
  logic [2*COUNT_W-1:0] plane_mul;
  logic [COUNT_W-1:0]   hi;
  logic [COUNT_W-1:0]   lo;
  logic [COUNT_W+1:0]   lo_cut;
  logic                 excessive;

  // Cube root step: (c+1)^3 and (c+1)^2 by adds
  assign c_ext    = CUBE_W'(c);
  assign cube_add = (sq << 1) + sq + (c_ext << 1) + c_ext + CUBE_W'(1);
  assign sq_add   = (c_ext << 1) + CUBE_W'(1);

  // Trial divisor: once d*d passes rest, rest itself is prime
  assign d_past_root = dsq > DIVR_W'(rest);
  assign d_try       = d_past_root ? rest : d;

  assign g_slot    = g[slot];
  assign g_mul     = g_slot * d;
  assign plane_mul = g[0] * g[1];

  // Spread check over the three sizes
  always_comb begin
    hi = g[0];
    lo = g[0];
    for (int k = 1; k < 3; k++) begin
      if (g[k] > hi) hi = g[k];
      if (g[k] < lo) lo = g[k];
    end
  end
  assign lo_cut    = (COUNT_W+2)'(lo) * (COUNT_W+2)'(EXCESS_CUTOFF);
  assign excessive = (COUNT_W+2)'(hi) > lo_cut;

  // Divider requests
  assign div_req.start    = (state == G_TEST) && (rest > COUNT_W'(1));
  assign div_req.dividend = DIVD_W'(rest);
  assign div_req.divisor  = DIVR_W'(d_try);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_IDLE;
      n_r   <= COUNT_W'(1);
      rest  <= COUNT_W'(1);
      d     <= COUNT_W'(2);
      dsq   <= DIVR_W'(4);
      slot  <= 2'd1;
      c     <= COUNT_W'(1);
      cube  <= CUBE_W'(1);
      sq    <= CUBE_W'(1);
      plane <= COUNT_W'(1);
      for (int k = 0; k < 3; k++) g[k] <= COUNT_W'(1);
    end else if (kick) begin
      state <= G_CUBE;
      n_r   <= n;
      rest  <= n;
      d     <= COUNT_W'(2);
      dsq   <= DIVR_W'(4);
      slot  <= 2'd1;
      c     <= COUNT_W'(1);
      cube  <= CUBE_W'(1);
      sq    <= CUBE_W'(1);
      for (int k = 0; k < 3; k++) g[k] <= COUNT_W'(1);
    end else begin
      case (state)
        G_IDLE: begin
        end
        // Advance c until c^3 covers the count
        G_CUBE: begin
          if (cube < CUBE_W'(n_r)) begin
            cube <= cube + cube_add;
            sq   <= sq + sq_add;
            c    <= c + COUNT_W'(1);
          end else begin
            state <= G_TEST;
          end
        end
        // Issue a trial division or finish factoring
        G_TEST: begin
          if (rest > COUNT_W'(1)) begin
            d     <= d_try;
            state <= G_WAIT;
          end else begin
            state <= G_CHECK;
          end
        end
        // Deal a found factor, else move to the next divisor
        G_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.rem == '0) begin
              g[slot] <= g_mul[COUNT_W-1:0];
              slot    <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
              rest    <= COUNT_W'(div_rsp.quot);
            end else begin
              d   <= d + COUNT_W'(1);
              dsq <= dsq + DIVR_W'({d, 1'b1});
            end
            state <= G_TEST;
          end
        end
        // Fall back to the cube grid when the sizes spread too far
        G_CHECK: begin
          if (excessive) begin
            for (int k = 0; k < 3; k++) g[k] <= c;
          end
          state <= G_PLANE;
        end
        G_PLANE: begin
          plane <= plane_mul[COUNT_W-1:0];
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end

  assign busy       = (state != G_IDLE);
  assign grid.gx    = g[0];
  assign grid.gy    = g[1];
  assign grid.gz    = g[2];
  assign grid.plane = plane;

endmodule

[rtl/lpg_pos.sv]
// Position sequencer: splits the index into layers and sums nine scaled
// axis terms on the shared divider. Depends on lpg_pkg.
module lpg_pos import lpg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [IDX_W-1:0]      idx,
  input  logic [COUNT_W-1:0]    n,
  input  grid_t                 grid,
  input  logic [AXIS_REG_W-1:0] first_axis,
  input  logic [AXIS_REG_W-1:0] second_axis,
  input  logic [AXIS_REG_W-1:0] third_axis,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  output logic                  busy,
  output logic                  done,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic                  index_error
);

  localparam logic [3:0] P_IDLE = 4'd0;
  localparam logic [3:0] P_DIV1 = 4'd1;
  localparam logic [3:0] P_W1   = 4'd2;
  localparam logic [3:0] P_DIV2 = 4'd3;
  localparam logic [3:0] P_W2   = 4'd4;
  localparam logic [3:0] P_MUL  = 4'd5;
  localparam logic [3:0] P_DIVT = 4'd6;
  localparam logic [3:0] P_WT   = 4'd7;
  localparam logic [3:0] P_OUT  = 4'd8;

  logic [3:0]              state;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        rem1;
  logic [IDX_W-1:0]        layer [3];
  logic [1:0]              a_sel;
  logic [1:0]              k_sel;
  logic [DIVD_W-1:0]       prod;
  logic                    neg;
  logic signed [POS_W-1:0] sum [3];
  logic                    err;

  logic [AXIS_REG_W-1:0]    axis_sel;
  logic [IDX_W-1:0]         layer_sel;
  logic [COUNT_W-1:0]       g_sel;
  logic signed [AXIS_W-1:0] comp;
  logic [AXIS_W-1:0]        mag;
  logic [NUM_W-1:0]         num;
  logic [AXIS_W+NUM_W-1:0]  mul_full;
  logic [DIVR_W-1:0]        den;
  logic [POS_W-1:0]         q_ext;
  logic signed [POS_W-1:0]  term;

  // Operand selection for the current term
  always_comb begin
    case (a_sel)
      2'd0: begin
        axis_sel  = first_axis;
        layer_sel = layer[0];
        g_sel     = grid.gx;
      end
      2'd1: begin
        axis_sel  = second_axis;
        layer_sel = layer[1];
        g_sel     = grid.gy;
      end
      default: begin
        axis_sel  = third_axis;
        layer_sel = layer[2];
        g_sel     = grid.gz;
      end
    endcase
  end

  assign comp     = axis_comp(axis_sel, k_sel);
  assign mag      = comp[AXIS_W-1] ? AXIS_W'(-comp) : AXIS_W'(comp);
  assign num      = {layer_sel, 1'b1};
  assign mul_full = mag * num;
  assign den      = {g_sel, 1'b0};
  assign q_ext    = POS_W'(div_rsp.quot);
  assign term     = neg ? -$signed(q_ext) : $signed(q_ext);

  // Divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIVD_W'(idx_r);
    div_req.divisor  = DIVR_W'(grid.plane);
    case (state)
      P_DIV1: div_req.start = 1'b1;
      P_DIV2: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIVD_W'(rem1);
        div_req.divisor  = DIVR_W'(grid.gx);
      end
      P_DIVT: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod;
        div_req.divisor  = den;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_IDLE;
      a_sel <= 2'd0;
      k_sel <= 2'd0;
      err   <= 1'b0;
      for (int k = 0; k < 3; k++) sum[k] <= '0;
    end else begin
      case (state)
        // Take a transaction; out-of-range indexes report at once
        P_IDLE: begin
          if (accept) begin
            idx_r <= idx;
            a_sel <= 2'd0;
            k_sel <= 2'd0;
            for (int k = 0; k < 3; k++) sum[k] <= '0;
            err   <= (COUNT_W'(idx) >= n);
            state <= (COUNT_W'(idx) >= n) ? P_OUT : P_DIV1;
          end
        end
        P_DIV1: state <= P_W1;
        // z layer and remainder within the plane
        P_W1: begin
          if (div_rsp.done) begin
            layer[2] <= IDX_W'(div_rsp.quot);
            rem1     <= IDX_W'(div_rsp.rem);
            state    <= P_DIV2;
          end
        end
        P_DIV2: state <= P_W2;
        // y and x layers
        P_W2: begin
          if (div_rsp.done) begin
            layer[1] <= IDX_W'(div_rsp.quot);
            layer[0] <= IDX_W'(div_rsp.rem);
            state    <= P_MUL;
          end
        end
        // Magnitude times 2*layer+1, sign kept aside
        P_MUL: begin
          prod  <= DIVD_W'(mul_full);
          neg   <= comp[AXIS_W-1];
          state <= P_DIVT;
        end
        P_DIVT: state <= P_WT;
        // Accumulate the truncated term and advance
        P_WT: begin
          if (div_rsp.done) begin
            sum[k_sel] <= sum[k_sel] + term;
            if (a_sel == 2'd2) begin
              a_sel <= 2'd0;
              k_sel <= k_sel + 2'd1;
              state <= (k_sel == 2'd2) ? P_OUT : P_MUL;
            end else begin
              a_sel <= a_sel + 2'd1;
              state <= P_MUL;
            end
          end
        end
        P_OUT:   state <= P_IDLE;
        default: state <= P_IDLE;
      endcase
    end
  end

  assign busy        = (state != P_IDLE);
  assign done        = (state == P_OUT);
  assign pos_x       = sum[0];
  assign pos_y       = sum[1];
  assign pos_z       = sum[2];
  assign index_error = err;

endmodule

[rtl/lattice_position_generator_top.sv]
// Top level of the lattice position generator: configuration registers,
// divider sharing and the two sequencers. Depends on lpg_pkg, lpg_div,
// lpg_grid and lpg_pos.
//
// Usage: program particle_count (byte address 0) and the three packed axis
// vectors (addresses 8, 16, 24) over the APB-style port; pready is always
// high. Writing particle_count starts the grid sizing: cube root search
// plus trial-division factoring of the count on the shared divider, which
// holds busy high meanwhile.
// A transaction is taken when start is high and busy is low; busy stays
// high until the result is shown. The result stands on pos_x, pos_y, pos_z
// and index_error for one cycle, marked by done, and must be taken then.
// Sequence: an out-of-range index shows its result in the cycle after it is
// taken; otherwise two index divisions and nine terms (multiply, issue,
// quotient shifts, collect) come before the result, and a new transaction
// is taken only once the last one has shown its result.
// Reset: particle_count is 1, the axes are zero, the grid is 1 x 1 x 1 and
// both sequencers are idle; no clearing pass is needed.
module lattice_position_generator_top import lpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // transaction channel
  input  logic                    start,
  output logic                    busy,
  input  logic [IDX_W-1:0]        particle_index,
  output logic                    done,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z,
  output logic                    index_error,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [COUNT_W-1:0]    particle_count;
  logic [AXIS_REG_W-1:0] first_axis;
  logic [AXIS_REG_W-1:0] second_axis;
  logic [AXIS_REG_W-1:0] third_axis;
  logic                  kick;

  logic [1:0]         reg_sel;
  logic               cfg_write;
  logic [COUNT_W-1:0] n_sat;
  logic               grid_busy;
  logic               pos_busy;
  logic               accept;
  grid_t              grid;
  div_req_t           grid_req;
  div_req_t           pos_req;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[PADDR_W-1:PADDR_W-2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers; a count write starts grid sizing next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= COUNT_W'(1);
      first_axis     <= '0;
      second_axis    <= '0;
      third_axis     <= '0;
      kick           <= 1'b0;
    end else begin
      kick <= cfg_write && (reg_sel == REG_COUNT);
      if (cfg_write) begin
        case (reg_sel)
          REG_COUNT:  particle_count <= pwdata[COUNT_W-1:0];
          REG_FIRST:  first_axis     <= pwdata[AXIS_REG_W-1:0];
          REG_SECOND: second_axis    <= pwdata[AXIS_REG_W-1:0];
          REG_THIRD:  third_axis     <= pwdata[AXIS_REG_W-1:0];
          default:    particle_count <= particle_count;
        endcase
      end
    end
  end

  // Register readback
  always_comb begin
    case (reg_sel)
      REG_COUNT:  prdata = PDATA_W'(particle_count);
      REG_FIRST:  prdata = PDATA_W'(first_axis);
      REG_SECOND: prdata = PDATA_W'(second_axis);
      REG_THIRD:  prdata = PDATA_W'(third_axis);
      default:    prdata = '0;
    endcase
  end

  // Clamp the count to the supported maximum
  assign n_sat = (particle_count > MAX_N) ? MAX_N : particle_count;

  assign busy   = grid_busy || pos_busy || kick;
  assign accept = start && !busy;

  // The user keeps the two sequencers from running together (not enforced here); the grid has the divider first
  assign div_req = grid_busy ? grid_req : pos_req;

  lpg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  lpg_grid u_grid (
    .clk     (clk),
    .rst     (rst),
    .kick    (kick),
    .n       (n_sat),
    .div_req (grid_req),
    .div_rsp (div_rsp),
    .grid    (grid),
    .busy    (grid_busy)
  );

  lpg_pos u_pos (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .idx         (particle_index),
    .n           (n_sat),
    .grid        (grid),
    .first_axis  (first_axis),
    .second_axis (second_axis),
    .third_axis  (third_axis),
    .div_req     (pos_req),
    .div_rsp     (div_rsp),
    .busy        (pos_busy),
    .done        (done),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .pos_z       (pos_z),
    .index_error (index_error)
  );

  // An accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after accepting a transaction");

  // The result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // An out-of-range index reports zero coordinates
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_error) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0))
    else $error("nonzero coordinates with index_error");

  // A count write blocks new transactions while the grid is sized
  a_count_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && reg_sel == REG_COUNT) |=> busy)
    else $error("busy not raised after a particle_count write");

endmodule

[tb/sv/lpg_position_checker.sv]
`timescale 1ns / 1ps
// Checker for the lattice position generator: tracks register writes,
// predicts each particle position and compares it with the block's results.
// Depends on lpg_pkg for widths and register codes.
module lpg_position_checker import lpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [IDX_W-1:0]        particle_index,
  input  logic                    done,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    index_error,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] z;
    logic             err;
  } placement_t;

  logic [COUNT_W-1:0]    count_reg;
  logic [AXIS_REG_W-1:0] axis_reg [3];
  longint                lattice [3];   // grid sizes along x, y, z
  placement_t            placement_q [$];
  int                    n_fail = 0;

  // Size the grid: deal prime factors to y, z, x in turn; fall back to a
  // cube when the grid gets too lopsided
  function automatic void size_lattice(input longint n);
    longint side, rest, d, hi, lo;
    int     slot;
    side = 1;
    rest = n;
    d    = 2;
    slot = 1;
    lattice[0] = 1;
    lattice[1] = 1;
    lattice[2] = 1;
    while (side * side * side < n) side++;
    while (rest > 1) begin
      if (d * d > rest) d = rest;
      if (rest % d == 0) begin
        lattice[slot] = lattice[slot] * d;
        slot = (slot + 1) % 3;
        rest = rest / d;
      end else begin
        d++;
      end
    end
    hi = lattice[0];
    lo = lattice[0];
    for (int k = 1; k < 3; k++) begin
      if (lattice[k] > hi) hi = lattice[k];
      if (lattice[k] < lo) lo = lattice[k];
    end
    if (hi > EXCESS_CUTOFF * lo) begin
      lattice[0] = side;
      lattice[1] = side;
      lattice[2] = side;
    end
  endfunction

  // Centre of the cell that holds particle idx
  function automatic placement_t place_particle(input logic [IDX_W-1:0] idx);
    placement_t               p;
    longint                   n, rest_idx, sum, mag, term;
    longint                   layer [3];
    logic [POS_W-1:0]         coord [3];
    logic signed [AXIS_W-1:0] comp;
    p = '0;
    n = (count_reg > MAX_PARTICLES) ? MAX_PARTICLES : count_reg;
    if (idx >= n) begin
      p.err = 1'b1;
      return p;
    end
    layer[2] = idx / (lattice[0] * lattice[1]);
    rest_idx = idx % (lattice[0] * lattice[1]);
    layer[1] = rest_idx / lattice[0];
    layer[0] = rest_idx % lattice[0];
    for (int k = 0; k < 3; k++) begin
      sum = 0;
      for (int a = 0; a < 3; a++) begin
        comp = axis_reg[a][AXIS_W*k +: AXIS_W];
        mag  = (comp < 0) ? -longint'(comp) : longint'(comp);
        term = (mag * (2 * layer[a] + 1)) / (2 * lattice[a]);
        sum  = (comp < 0) ? sum - term : sum + term;
      end
      coord[k] = sum[POS_W-1:0];
    end
    p.x = coord[0];
    p.y = coord[1];
    p.z = coord[2];
    return p;
  endfunction

  task automatic compare_field(input string what, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, what, $signed(want), $signed(got));
      n_fail++;
    end
  endtask

  always @(posedge clk) begin : watch
    placement_t want;
    if (rst) begin
      count_reg = 1;
      axis_reg[0] = '0;
      axis_reg[1] = '0;
      axis_reg[2] = '0;
      size_lattice(1);
      placement_q.delete();
    end else begin
      // Retire the oldest expected placement against this result
      if (done) begin
        if (placement_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual x=%0d y=%0d z=%0d err=%0b",
                   $time, pos_x, pos_y, pos_z, index_error);
          n_fail++;
        end else begin
          want = placement_q.pop_front();
          compare_field("pos_x", want.x, pos_x);
          compare_field("pos_y", want.y, pos_y);
          compare_field("pos_z", want.z, pos_z);
          compare_field("index_error", POS_W'(want.err), POS_W'(index_error));
        end
      end
      // Predict each accepted transaction
      if (start && !busy) placement_q = {placement_q, place_particle(particle_index)};
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_COUNT: begin
            count_reg = pwdata[COUNT_W-1:0];
            size_lattice((count_reg > MAX_PARTICLES) ? MAX_PARTICLES : count_reg);
          end
          REG_FIRST:  axis_reg[0] = pwdata[AXIS_REG_W-1:0];
          REG_SECOND: axis_reg[1] = pwdata[AXIS_REG_W-1:0];
          REG_THIRD:  axis_reg[2] = pwdata[AXIS_REG_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= n_fail;
    pending    <= placement_q.size();
  end

endmodule

[tb/sv/lattice_position_generator_top_test.sv]
`timescale 1ns / 1ps
// Testbench top for the lattice position generator: drives register writes
// and particle indexes, and gives the verdict. Depends on lpg_pkg,
// lpg_position_checker and the RTL under rtl/.
module lattice_position_generator_top_test;
  import lpg_pkg::*;

  localparam logic [AXIS_W-1:0] COMP_MIN = {1'b1, {(AXIS_W-1){1'b0}}};
  localparam logic [AXIS_W-1:0] COMP_MAX = {1'b0, {(AXIS_W-1){1'b1}}};
  localparam logic [AXIS_W-1:0] COMP_ONE = AXIS_W'(1);
  localparam logic [AXIS_W-1:0] COMP_NEG = {AXIS_W{1'b1}};

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    start = 1'b0;
  logic [IDX_W-1:0]        particle_index = '0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [PADDR_W-1:0]      paddr = '0;
  logic [PDATA_W-1:0]      pwdata = '0;
  logic                    busy, done, index_error, pready;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic [PDATA_W-1:0]      prdata;
  int                      fail_count, pending;
  int                      eff_n = 1;   // particle count after saturation

  always #5 clk = ~clk;

  lattice_position_generator_top u_dut (
    .clk, .rst, .start, .busy, .particle_index, .done,
    .pos_x, .pos_y, .pos_z, .index_error,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lpg_position_checker u_checker (
    .clk, .rst, .start, .busy, .particle_index, .done,
    .pos_x, .pos_y, .pos_z, .index_error,
    .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .fail_count, .pending
  );

  // APB write: setup cycle, then access cycle until pready
  task automatic reg_write(input logic [1:0] sel, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop start and hold until every expected placement has come back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Present one index and hold it until the block takes it
  task automatic send_index(input int idx);
    start          <= 1'b1;
    particle_index <= IDX_W'(idx);
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Reprogram the lattice while idle; count goes last since it starts sizing
  task automatic set_lattice(input int count, input logic [AXIS_REG_W-1:0] first,
                             input logic [AXIS_REG_W-1:0] second,
                             input logic [AXIS_REG_W-1:0] third);
    drain();
    reg_write(REG_FIRST, PDATA_W'(first));
    reg_write(REG_SECOND, PDATA_W'(second));
    reg_write(REG_THIRD, PDATA_W'(third));
    reg_write(REG_COUNT, PDATA_W'(count));
    eff_n = (count > MAX_PARTICLES) ? MAX_PARTICLES : count;
  endtask

  // Axis vector with components biased toward the extremes and zero
  function automatic logic [AXIS_REG_W-1:0] random_axis();
    logic [AXIS_REG_W-1:0] v;
    logic [AXIS_W-1:0]     c;
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 9))
        0:       c = COMP_MIN;
        1:       c = COMP_MAX;
        2:       c = '0;
        3:       c = -AXIS_W'($urandom_range(1, 1023));
        default: c = AXIS_W'($urandom);
      endcase
      v[AXIS_W*k +: AXIS_W] = c;
    end
    return v;
  endfunction

  // Mostly small counts so sizing stays short; a few large, saturating and zero ones
  function automatic int random_count();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(MAX_PARTICLES + 1, 2**COUNT_W - 1);
      2, 3:    return $urandom_range(4097, MAX_PARTICLES);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  // Mostly in-range indexes, some past the count, some at the last particle
  function automatic int random_index();
    if (eff_n == 0 || $urandom_range(0, 9) == 0) begin
      if (eff_n >= 2**IDX_W) return $urandom_range(0, 2**IDX_W - 1);
      return $urandom_range(eff_n, 2**IDX_W - 1);
    end
    if ($urandom_range(0, 9) == 0) return eff_n - 1;
    return $urandom_range(0, eff_n - 1);
  endfunction

  task automatic run_random_phase(input int items, input bit idle_on);
    for (int i = 0; i < items; i++) begin
      send_index(random_index());
      if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one particle at the origin
    send_index(0);
    send_index(1);
    pause(3);
    send_index(2**IDX_W - 1);

    // Zero count: everything out of range
    set_lattice(0, {3{COMP_MAX}}, {3{COMP_MIN}}, {AXIS_REG_W{1'b1}});
    send_index(0);
    send_index(2**IDX_W - 1);

    // Full count with extreme axes
    set_lattice(MAX_PARTICLES, {3{COMP_MIN}}, {3{COMP_MAX}},
                {AXIS_W'(0), COMP_NEG, COMP_ONE});
    send_index(0);
    send_index(2**IDX_W - 1);
    pause(7);
    send_index(32767);
    send_index(1234);

    // Count above the maximum saturates
    set_lattice(2**COUNT_W - 1, {3{COMP_NEG}}, {3{COMP_MAX}}, {3{COMP_MIN}});
    send_index(2**IDX_W - 1);
    send_index(0);

    // Prime count: lopsided grid falls back to a cube
    set_lattice(65521, {3{COMP_MAX}}, {3{COMP_MAX}}, {3{COMP_MAX}});
    send_index(0);
    send_index(65520);
    send_index(65521);

    // Small balanced grid, last particle and first index past it
    set_lattice(12, {3{COMP_MIN}}, {COMP_ONE, COMP_MAX, COMP_NEG}, {3{COMP_MAX}});
    send_index(0);
    send_index(5);
    send_index(11);
    send_index(12);

    // Random settings and indexes; no idling in every third phase or in the last phases
    for (int p = 0; p < 20; p++) begin
      set_lattice(random_count(), random_axis(), random_axis(), random_axis());
      run_random_phase(50, p < 17 && p % 3 != 0);
    end

    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("lattice_position_generator_top_test: done, clean");
    end else begin
      $display("lattice_position_generator_top_test: done, errors");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #(64'd50_000_000);
    $display("lattice_position_generator_top_test: done, errors");
    $finish;
  end

endmodule
